### hdl/pipct_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon crossing test: shared package
// Word formats, status and request codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pipct_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 32;
   localparam int VADDR_W      = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int PROD_W       = 2 * DIFF_W;

   localparam logic signed [COORD_BITS-1:0] RAY_FAR_X_RESET = COORD_BITS'(100000000);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic                          req_type;
      logic signed [COORD_BITS-1:0]  coord_x;
      logic signed [COORD_BITS-1:0]  coord_y;
      logic                          first_vertex;
   } req_word_type;

   typedef struct packed {
      logic             inside_res;
      logic [CNT_W-1:0] crossing_count;
      logic [1:0]       status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_GETB,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_ACC,
      ST_DONE
   } pipct_state_type;

   // Difference of two coordinates, one bit wider so that it is exact.
   function automatic logic signed [DIFF_W-1:0] diff_ext(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      diff_ext = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
   endfunction

   function automatic logic is_pos(input logic signed [DIFF_W-1:0] d);
      is_pos = !d[DIFF_W-1] && (d != '0);
   endfunction

endpackage

`default_nettype wire

### hdl/point_in_polygon_crossing_test_unit.sv
// ----------------------------------------------------------------------------
// Point-in-polygon crossing test unit
// Holds a polygon in a vertex memory and counts the edges that a horizontal
// ray from the query point crosses, using one shared signed multiplier.
// ----------------------------------------------------------------------------
// Vertex load: loads may arrive back to back.
// Query on n stored vertices: each edge steps through GETB, MUL0, MUL1, MUL2
// and ACC, the three MUL states using the one shared 33x33 multiplier; the
// next word is taken once the result word is registered.
// Query on an empty polygon: the sequencer goes straight to the final state.
// Synchronous reset clears the vertex count, overflow flag, result valid flag
// and sequencer, and loads the ray end register; the vertex memory is not cleared.
`default_nettype none

module point_in_polygon_crossing_test_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  pipct_pkg::req_word_type    req_word,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output pipct_pkg::rsp_word_type    rsp_word,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [31:0]                 csr_wdata
);
   import pipct_pkg::*;

   pipct_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic signed [COORD_BITS-1:0] far_x_ff;

   logic signed [COORD_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [DIFF_W-1:0]     dfq_ff, dfq_in;
   logic [CNT_W-1:0]             n_ff, n_in, idx_ff, idx_in;
   logic signed [COORD_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [COORD_BITS-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [COORD_BITS-1:0] fx0_ff, fx0_in, fy0_ff, fy0_in;
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic signed [DIFF_W-1:0]     dxab_ff, dxab_in, dyab_ff, dyab_in;
   logic signed [DIFF_W-1:0]     dqx_ff, dqx_in, dqy_ff, dqy_in, dfx_ff, dfx_in;
   logic                         s12_ff, s12_in, last_ff, last_in, s3_ff, s3_in;
   logic signed [PROD_W-1:0]     mult_ff, p_ff, p_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [1:0]                   status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_word_ff, rsp_word_in;

   logic signed [COORD_BITS-1:0] x_mem [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] y_mem [MAX_VERTICES];

   logic                  req_take, is_load, is_query, rsp_free;
   logic                  wr_en;
   logic [VADDR_W-1:0]    wr_addr, rd_addr;
   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [COORD_BITS-1:0] b_x, b_y;
   logic signed [DIFF_W-1:0] dby;
   logic                  last_edge, s_a, s_b, s4;

   assign req_take  = req_valid && !req_stall;
   assign is_load   = req_take && (req_word.req_type == REQ_LOAD);
   assign is_query  = req_take && (req_word.req_type == REQ_QUERY);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_edge = (idx_ff == n_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_query) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_FIRST;
            end
         end
         ST_FIRST: state_in = ST_GETB;
         ST_GETB:  state_in = ST_MUL0;
         ST_MUL0:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_ACC;
         ST_ACC:   state_in = last_ff ? ST_DONE : ST_GETB;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs: handshake, memory ports and multiplier operands.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      wr_en     = 1'b0;
      wr_addr   = req_word.first_vertex ? '0 : count_ff[VADDR_W-1:0];
      rd_addr   = idx_in[VADDR_W-1:0];
      mul_a     = dyab_ff;
      mul_b     = dfx_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            wr_en   = is_load &&
                      (req_word.first_vertex || (count_ff < CNT_W'(MAX_VERTICES)));
         end
         ST_MUL0: begin
            mul_a = dxab_ff;
            mul_b = dqy_ff;
         end
         ST_MUL1: begin
            mul_a = dyab_ff;
            mul_b = dqx_ff;
         end
         default: ;
      endcase
   end

   // Edge geometry for the edge that ends at the vertex just read, or at the
   // first vertex for the closing edge.
   always_comb begin
      b_x = last_edge ? fx0_ff : rd_x_ff;
      b_y = last_edge ? fy0_ff : rd_y_ff;
      dby = diff_ext(b_y, qy_ff);
      // The ray orientation of a vertex is positive only when the ray points
      // right and the vertex lies above, or left and below.
      s_a = (is_pos(dfq_ff) && dqy_in[DIFF_W-1]) || (dfq_ff[DIFF_W-1] && is_pos(dqy_in));
      s_b = (is_pos(dfq_ff) && is_pos(dby)) || (dfq_ff[DIFF_W-1] && dby[DIFF_W-1]);
      s4  = (p_ff > mult_ff);
   end

   // Datapath next values.
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      dfq_in       = dfq_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      fx0_in       = fx0_ff;
      fy0_in       = fy0_ff;
      dxab_in      = diff_ext(b_x, ax_ff);
      dyab_in      = diff_ext(b_y, ay_ff);
      dqx_in       = diff_ext(qx_ff, ax_ff);
      dqy_in       = diff_ext(qy_ff, ay_ff);
      dfx_in       = diff_ext(far_x_ff, ax_ff);
      s12_in       = s12_ff;
      last_in      = last_ff;
      s3_in        = s3_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_load) begin
               if (req_word.first_vertex) begin
                  count_in = CNT_W'(1);
                  ovf_in   = 1'b0;
               end else if (count_ff < CNT_W'(MAX_VERTICES)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (is_query) begin
               qx_in     = req_word.coord_x;
               qy_in     = req_word.coord_y;
               dfq_in    = diff_ext(far_x_ff, req_word.coord_x);
               n_in      = count_ff;
               idx_in    = CNT_W'(1);
               cnt_in    = '0;
               status_in = (count_ff == '0) ? STATUS_EMPTY :
                           (ovf_ff ? STATUS_OVERFLOW : STATUS_OK);
            end
         end
         ST_FIRST: begin
            ax_in  = rd_x_ff;
            ay_in  = rd_y_ff;
            fx0_in = rd_x_ff;
            fy0_in = rd_y_ff;
         end
         ST_GETB: begin
            bx_in   = b_x;
            by_in   = b_y;
            s12_in  = (s_a != s_b);
            last_in = last_edge;
         end
         ST_MUL1: begin
            p_in = mult_ff;
         end
         ST_MUL2: begin
            s3_in = (p_ff > mult_ff);
         end
         ST_ACC: begin
            if (s12_ff && (s3_ff != s4)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (!last_ff) begin
               ax_in  = bx_ff;
               ay_in  = by_ff;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.inside_res     = cnt_ff[0];
               rsp_word_in.crossing_count = cnt_ff;
               rsp_word_in.status         = status_ff;
            end
         end
         default: ;
      endcase
   end

   // Vertex memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= req_word.coord_x;
         y_mem[wr_addr] <= req_word.coord_y;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   // Shared multiplier, registered.
   always_ff @(posedge clock) begin
      mult_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         far_x_ff     <= RAY_FAR_X_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            far_x_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      dfq_ff      <= dfq_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      fx0_ff      <= fx0_in;
      fy0_ff      <= fy0_in;
      dxab_ff     <= dxab_in;
      dyab_ff     <= dyab_in;
      dqx_ff      <= dqx_in;
      dqy_ff      <= dqy_in;
      dfx_ff      <= dfx_in;
      s12_ff      <= s12_in;
      last_ff     <= last_in;
      s3_ff       <= s3_in;
      p_ff        <= p_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   // The stored vertex count never passes the memory depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond memory depth");

   // While edges are walked the edge index stays within the polygon.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GETB) |-> (idx_ff >= CNT_W'(1)) && (idx_ff <= n_ff))
      else $error("edge index outside polygon");

   // No more crossings than edges tested so far.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |=> (cnt_ff <= idx_ff))
      else $error("crossing count exceeds edges tested");

   // After a vertex load the polygon is never empty.
   assert property (@(posedge clock) disable iff (reset)
      is_load |=> (count_ff != '0))
      else $error("vertex load left polygon empty");

   // A word is only written to the result register from the final state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("result word produced outside final state");

endmodule

`default_nettype wire

### sim/tb_point_in_polygon_crossing_test_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the point-in-polygon crossing test unit
// Loads polygons vertex by vertex and queries points against them under
// several ray end settings. An in-bench scoreboard predicts each result by
// exact integer ray casting and checks every result word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_in_polygon_crossing_test_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import pipct_pkg::*;

   localparam int RUN_LIMIT    = 1000000;
   localparam int SETTLE       = 8;
   localparam int PHASE_ITEMS  = 60;
   localparam int HOLD_CYCLES  = 600;
   localparam int C_MIN        = 32'sh8000_0000;
   localparam int C_MAX        = 32'sh7FFF_FFFF;

   // Scoreboard: shadow copy of the vertex store and the ray end register,
   // plus the queue of answers still owed by the block.
   class crossing_scoreboard;
      logic signed [COORD_BITS-1:0] vert_x [MAX_VERTICES];
      logic signed [COORD_BITS-1:0] vert_y [MAX_VERTICES];
      int unsigned                  vert_count;
      bit                           dropped;
      logic signed [COORD_BITS-1:0] far_x;
      rsp_word_type                 expected_answers [$];
      int                           errors;

      function new();
         vert_count = 0;
         dropped    = 1'b0;
         far_x      = RAY_FAR_X_RESET;
         errors     = 0;
      endfunction

      function void set_far_x(logic [31:0] value);
         far_x = value;
      endfunction

      // True when (x1-x0)*(y2-y0) > (y1-y0)*(x2-x0); collinear gives false.
      function bit turns_left(longint x0, longint y0, longint x1, longint y1,
                              longint x2, longint y2);
         logic signed [67:0] d1, d2, d3, d4, lhs, rhs;
         d1  = x1 - x0;
         d2  = y2 - y0;
         d3  = y1 - y0;
         d4  = x2 - x0;
         lhs = d1 * d2;
         rhs = d3 * d4;
         return lhs > rhs;
      endfunction

      function rsp_word_type predict_answer(longint qx, longint qy);
         rsp_word_type ans;
         int unsigned  n, j, hits;
         longint       ax, ay, bx, by, fx;
         bit           s1, s2, s3, s4;
         ans  = '0;
         n    = (vert_count > MAX_VERTICES) ? MAX_VERTICES : vert_count;
         hits = 0;
         fx   = far_x;
         if (n == 0) begin
            ans.status = STATUS_EMPTY;
            return ans;
         end
         for (int unsigned i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            ax = vert_x[i];
            ay = vert_y[i];
            bx = vert_x[j];
            by = vert_y[j];
            s1 = turns_left(qx, qy, fx, qy, ax, ay);
            s2 = turns_left(qx, qy, fx, qy, bx, by);
            s3 = turns_left(ax, ay, bx, by, qx, qy);
            s4 = turns_left(ax, ay, bx, by, fx, qy);
            if (s1 != s2 && s3 != s4)
               hits++;
         end
         ans.inside_res     = hits[0];
         ans.crossing_count = CNT_W'((hits > 511) ? 511 : hits);
         ans.status         = dropped ? STATUS_OVERFLOW : STATUS_OK;
         return ans;
      endfunction

      function void note_request(req_word_type w);
         if (w.req_type == REQ_LOAD) begin
            if (w.first_vertex) begin
               vert_count = 0;
               dropped    = 1'b0;
            end
            if (vert_count < MAX_VERTICES) begin
               vert_x[vert_count] = w.coord_x;
               vert_y[vert_count] = w.coord_y;
               vert_count++;
            end else begin
               dropped = 1'b1;
            end
         end else begin
            expected_answers.push_back(predict_answer(w.coord_x, w.coord_y));
         end
      endfunction

      function void compare_field(string name, logic [8:0] want, logic [8:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result word, inside %0d count %0d status %0d",
                     $time, got.inside_res, got.crossing_count, got.status);
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         compare_field("inside_res", 9'(want.inside_res), 9'(got.inside_res));
         compare_field("crossing_count", want.crossing_count, got.crossing_count);
         compare_field("status", 9'(want.status), 9'(got.status));
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_word_type  req_word = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_word_type  rsp_word;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [31:0]   csr_wdata = '0;

   crossing_scoreboard sb = new();
   int  cycle_count = 0;
   int  items_sent = 0;
   int  sender_calm = 0;
   bit  hold_request = 1'b0;

   point_in_polygon_crossing_test_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("point_in_polygon_crossing_test_unit: mismatch");
         $finish;
      end
   end

   function automatic req_word_type make_word(logic kind, int x, int y, logic first);
      req_word_type w;
      w.req_type     = kind;
      w.coord_x      = x;
      w.coord_y      = y;
      w.first_vertex = first;
      return w;
   endfunction

   function automatic int pick_near(int centre, int spread);
      return centre + int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // Offer one word and hold it until taken, then maybe leave a gap.
   task automatic offer_word(req_word_type w);
      int r, gap;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
      items_sent++;
      gap = 0;
      if (sender_calm > 0) begin
         sender_calm--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3)
            sender_calm = $urandom_range(20, 60);
         else if (r < 75)
            gap = 0;
         else if (r < 96)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for every owed answer, then let a trailing load drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_far_x(logic [31:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_far_x(value);
   endtask

   // One polygon: a fresh load sequence with random content, then queries.
   // Now and then a restart or a query breaks into the load sequence; a
   // polygon that fills the whole store is never restarted part way.
   task automatic run_polygon(int size);
      bit full_range;
      int cx, cy, spread, x, y, nq, r, qx, qy;
      int ys [$];
      int xs [$];
      full_range = ($urandom_range(0, 9) == 0);
      cx         = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      cy         = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      spread     = 1 << $urandom_range(2, 12);
      for (int i = 0; i < size; i++) begin
         x = full_range ? int'($urandom) : pick_near(cx, spread);
         y = full_range ? int'($urandom) : pick_near(cy, spread);
         xs.push_back(x);
         ys.push_back(y);
         offer_word(make_word(REQ_LOAD, x, y,
                              (i == 0) || ((size < MAX_VERTICES) &&
                                           ($urandom_range(0, 39) == 0))));
         if ($urandom_range(0, 29) == 0)
            offer_word(make_word(REQ_QUERY, pick_near(cx, spread), pick_near(cy, spread),
                                 1'($urandom_range(0, 1))));
      end
      nq = (size > 50) ? 2 : $urandom_range(1, 5);
      for (int i = 0; i < nq; i++) begin
         r  = $urandom_range(0, 9);
         qx = pick_near(cx, 2 * spread);
         qy = pick_near(cy, spread + spread / 2);
         if (r < 2) begin
            // Ray level with a vertex, sometimes from the vertex itself.
            r  = $urandom_range(0, ys.size() - 1);
            qy = ys[r];
            if ($urandom_range(0, 2) == 0)
               qx = xs[r];
         end else if (r == 2 || full_range) begin
            qx = $urandom;
            qy = $urandom;
         end
         offer_word(make_word(REQ_QUERY, qx, qy, 1'($urandom_range(0, 1))));
      end
   endtask

   // Result side: checks each taken word and drives the stall pattern.
   initial begin
      int  hold_left, stall_left, calm_left, r;
      bit  hold_done, next_stall;
      hold_left  = 0;
      stall_left = 0;
      calm_left  = 0;
      hold_done  = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_word);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         next_stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
               calm_left = $urandom_range(20, 200);
            end else if (r >= 12 && r < 19) begin
               stall_left = $urandom_range(0, 2);
               next_stall = 1'b1;
            end else if (r == 19) begin
               stall_left = $urandom_range(20, 80);
               next_stall = 1'b1;
            end
         end
         rsp_stall <= next_stall;
      end
   end

   initial begin
      logic [31:0] far_settings [6];
      int          phase_start;
      far_settings[0] = 32'h7FFF_FFFF;
      far_settings[1] = 32'h8000_0000;
      far_settings[2] = 32'd0;
      far_settings[3] = 32'd100000000;
      far_settings[4] = $urandom;
      far_settings[5] = $urandom_range(0, 4095) - 2048;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty polygon, a lone vertex, a square, extremes.
      offer_word(make_word(REQ_QUERY, 0, 0, 1'b1));
      offer_word(make_word(REQ_LOAD, 10, 10, 1'b0));
      offer_word(make_word(REQ_QUERY, 5, 10, 1'b0));
      offer_word(make_word(REQ_LOAD, 0, 0, 1'b1));
      offer_word(make_word(REQ_LOAD, 100, 0, 1'b0));
      offer_word(make_word(REQ_LOAD, 100, 100, 1'b0));
      offer_word(make_word(REQ_LOAD, 0, 100, 1'b0));
      offer_word(make_word(REQ_QUERY, 50, 50, 1'b0));
      offer_word(make_word(REQ_QUERY, 150, 50, 1'b0));
      offer_word(make_word(REQ_QUERY, -50, 50, 1'b0));
      offer_word(make_word(REQ_QUERY, 50, 0, 1'b0));
      offer_word(make_word(REQ_QUERY, 50, 100, 1'b0));
      offer_word(make_word(REQ_QUERY, 0, 50, 1'b0));
      offer_word(make_word(REQ_LOAD, C_MIN, C_MIN, 1'b1));
      offer_word(make_word(REQ_LOAD, C_MAX, C_MIN, 1'b0));
      offer_word(make_word(REQ_LOAD, 0, C_MAX, 1'b0));
      offer_word(make_word(REQ_QUERY, 0, 0, 1'b0));
      offer_word(make_word(REQ_QUERY, C_MAX, C_MAX, 1'b1));
      offer_word(make_word(REQ_QUERY, C_MIN, 0, 1'b0));
      wait_idle();
      write_far_x(32'h7FFF_FFFF);
      offer_word(make_word(REQ_QUERY, 0, 0, 1'b0));
      offer_word(make_word(REQ_QUERY, C_MIN, -1, 1'b0));
      wait_idle();
      write_far_x(32'h8000_0000);
      offer_word(make_word(REQ_QUERY, 0, 0, 1'b0));
      offer_word(make_word(REQ_QUERY, C_MAX, 5, 1'b0));

      // Random part, one ray end setting per phase.
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_far_x(far_settings[p]);
         phase_start = items_sent;
         if (p == 1)
            hold_request = 1'b1;
         if (p == 2) begin
            // Fill the store exactly, then push two more vertices past it.
            run_polygon(MAX_VERTICES);
            offer_word(make_word(REQ_LOAD, $urandom, $urandom, 1'b0));
            offer_word(make_word(REQ_LOAD, $urandom, $urandom, 1'b0));
            offer_word(make_word(REQ_QUERY, $urandom_range(0, 4095), 0, 1'b0));
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
               run_polygon($urandom_range(1, 2));
            else if ($urandom_range(0, 14) == 0)
               run_polygon($urandom_range(20, 40));
            else
               run_polygon($urandom_range(3, 8));
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_answers.size() == 0)
         $display("point_in_polygon_crossing_test_unit: match");
      else
         $display("point_in_polygon_crossing_test_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
